// ----- hdl/motor_current_block_averager_assert.svh -----
// ----------------------------------------------------------------------------
// motor current block averager assertion macros
// shared property forms for the averager's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MOTOR_CURRENT_BLOCK_AVERAGER_ASSERT_SVH
`define MOTOR_CURRENT_BLOCK_AVERAGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mcba_pkg.sv -----
// ----------------------------------------------------------------------------
// mcba_pkg
// types and constants shared by the motor current block averager
// ----------------------------------------------------------------------------
package mcba_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_AVG_LEN = 1024;

  localparam int AVG_CNT_W = $clog2(MAX_AVG_LEN) + 1;
  localparam int SUM_W     = SAMPLE_BITS + AVG_CNT_W - 1;
  localparam int CAL_CNT_W = 8;
  localparam int CAL_SUM_W = SAMPLE_BITS + CAL_CNT_W;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int BYTE_W    = 8;
  localparam int PROD_W    = SAMPLE_BITS + GAIN_W;
  localparam int REM_W     = AVG_CNT_W + 1;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZCAL_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

  localparam logic [AVG_CNT_W-1:0] AVG_LEN_RST  = 11'd16;
  localparam logic [CAL_CNT_W-1:0] ZCAL_LEN_RST = 8'd100;
  localparam logic [GAIN_W-1:0]    GAIN_RST     = 16'd256;

  typedef struct packed {
    logic [11:0] adc_sample;
    logic        motor_run;
    logic        feed_phase;
    logic        reverse_polarity;
  } in_word_t;

  typedef struct packed {
    logic        average_done;
    logic [11:0] average_current;
    logic [7:0]  scaled_current;
    logic [11:0] zero_level;
  } out_word_t;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [AVG_CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/mcba_div.sv -----
// ----------------------------------------------------------------------------
// mcba_div
// restoring divider, one quotient bit per cycle, done pulses on the last bit
// ----------------------------------------------------------------------------
module mcba_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mcba_pkg::div_req_t req,
  output mcba_pkg::div_rsp_t rsp
);
  import mcba_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]     rem_r;
  logic [SUM_W-1:0]     quo_r;
  logic [AVG_CNT_W-1:0] divisor_r;

  logic [REM_W-1:0] trial;
  logic             fits;
  logic             last_bit;

  assign trial    = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};
  assign fits     = trial >= {1'b0, divisor_r};
  assign last_bit = busy_r && (cnt_r == DIV_CNT_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_bit && !req.start;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (trial - {1'b0, divisor_r}) : trial;
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- hdl/mcba_scale.sv -----
// ----------------------------------------------------------------------------
// mcba_scale
// average times q8.8 gain, registered product, saturated byte out
// ----------------------------------------------------------------------------
module mcba_scale (
  input  logic                           clk,
  input  logic                           load,
  input  logic [mcba_pkg::SAMPLE_BITS-1:0] avg,
  input  logic [mcba_pkg::GAIN_W-1:0]      gain,
  output logic [mcba_pkg::BYTE_W-1:0]      scaled
);
  import mcba_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(avg) * PROD_W'(gain);
    end
  end

  // anything above the byte after dropping the fraction saturates
  assign scaled = (prod_r[PROD_W-1:GAIN_FRAC+BYTE_W] != '0) ? {BYTE_W{1'b1}}
                                                           : prod_r[GAIN_FRAC+BYTE_W-1:GAIN_FRAC];

endmodule

// ----- hdl/motor_current_block_averager.sv -----
// ----------------------------------------------------------------------------
// motor_current_block_averager
// block average of motor current offset with learned sensor zero level
// ----------------------------------------------------------------------------
// Every accepted word produces exactly one result word. A word that does not
// close a block passes from accept through the update step to the result
// register; a word that closes a motor current block or a zero calibration
// block also runs the shared restoring divider, which produces one quotient
// bit per cycle over the 22-bit sum, followed for motor blocks by a multiply
// step and a saturate step. in_stall stays high from accept until the result
// is in the output register; a result still waiting on out_stall does not
// block the next accept, only the next result load. Config registers may be
// written at any time the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module motor_current_block_averager (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mcba_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mcba_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mcba_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SCALE  = 3'd3;
  localparam logic [2:0] S_SAT    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // config registers
  logic [AVG_CNT_W-1:0] avg_len_r;
  logic [CAL_CNT_W-1:0] zcal_len_r;
  logic [GAIN_W-1:0]    gain_r;

  // accumulator state
  logic [SUM_W-1:0]       run_sum_r;
  logic [AVG_CNT_W-1:0]   run_count_r;
  logic [SAMPLE_BITS-1:0] held_avg_r;
  logic [BYTE_W-1:0]      held_scaled_r;
  logic [CAL_SUM_W-1:0]   cal_sum_r;
  logic [CAL_CNT_W-1:0]   cal_count_r;
  logic [SAMPLE_BITS-1:0] zero_offset_r;
  logic                   done_r;

  in_word_t  item_r;
  out_word_t out_data_r;
  logic      out_valid_r;

  // update-step signals
  logic [SAMPLE_BITS-1:0] sample;
  logic                   active;
  logic [SAMPLE_BITS:0]   diff_norm;
  logic [SAMPLE_BITS:0]   diff_rev;
  logic [SAMPLE_BITS-1:0] add_val;
  logic [SUM_W-1:0]       run_sum_add;
  logic [AVG_CNT_W-1:0]   run_cnt_inc;
  logic [AVG_CNT_W-1:0]   len_eff;
  logic                   run_hit;
  logic [CAL_SUM_W-1:0]   cal_sum_add;
  logic [CAL_CNT_W-1:0]   cal_cnt_inc;
  logic [CAL_CNT_W-1:0]   clen_eff;
  logic                   cal_hit;
  logic                   out_free;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [BYTE_W-1:0]      scaled;

  assign sample = item_r.adc_sample;
  assign active = item_r.motor_run | item_r.feed_phase;

  // one-sided offset from the zero level, negative side adds nothing
  assign diff_norm = {1'b0, zero_offset_r} - {1'b0, sample};
  assign diff_rev  = {1'b0, sample} - {1'b0, zero_offset_r};
  always_comb begin
    if (item_r.reverse_polarity) begin
      add_val = diff_rev[SAMPLE_BITS] ? '0 : diff_rev[SAMPLE_BITS-1:0];
    end else begin
      add_val = diff_norm[SAMPLE_BITS] ? '0 : diff_norm[SAMPLE_BITS-1:0];
    end
  end

  assign run_sum_add = run_sum_r + SUM_W'(add_val);
  assign run_cnt_inc = run_count_r + 1'b1;

  // zero length acts as one, long length clamps to the maximum
  always_comb begin
    if (avg_len_r == '0) begin
      len_eff = AVG_CNT_W'(1);
    end else if (avg_len_r > AVG_CNT_W'(MAX_AVG_LEN)) begin
      len_eff = AVG_CNT_W'(MAX_AVG_LEN);
    end else begin
      len_eff = avg_len_r;
    end
  end
  assign run_hit = run_cnt_inc >= len_eff;

  assign cal_sum_add = cal_sum_r + CAL_SUM_W'(sample);
  assign cal_cnt_inc = cal_count_r + 1'b1;
  assign clen_eff    = (zcal_len_r == '0) ? CAL_CNT_W'(1) : zcal_len_r;
  assign cal_hit     = cal_cnt_inc >= clen_eff;

  // one divider serves both the motor block and the zero calibration block
  assign div_req.start    = (state_r == S_UPDATE) && (active ? run_hit : cal_hit);
  assign div_req.dividend = active ? run_sum_add : SUM_W'(cal_sum_add);
  assign div_req.divisor  = active ? run_cnt_inc : AVG_CNT_W'(cal_cnt_inc);

  mcba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mcba_scale u_scale (
    .clk    (clk),
    .load   (state_r == S_SCALE),
    .avg    (held_avg_r),
    .gain   (gain_r),
    .scaled (scaled)
  );

  // result register free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_nxt = div_req.start ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = active ? S_SCALE : S_DONE;
        end
      end
      S_SCALE: state_nxt = S_SAT;
      S_SAT:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_len_r  <= AVG_LEN_RST;
      zcal_len_r <= ZCAL_LEN_RST;
      gain_r     <= GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AVG_LEN:  avg_len_r  <= cfg_data[AVG_CNT_W-1:0];
        CFG_ZCAL_LEN: zcal_len_r <= cfg_data[CAL_CNT_W-1:0];
        CFG_GAIN:     gain_r     <= cfg_data[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  // sequencer and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      run_sum_r     <= '0;
      run_count_r   <= '0;
      held_avg_r    <= '0;
      held_scaled_r <= '0;
      cal_sum_r     <= '0;
      cal_count_r   <= '0;
      zero_offset_r <= '0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result register fills when free, otherwise empties once taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_UPDATE: begin
          if (active) begin
            run_sum_r   <= run_sum_add;
            run_count_r <= run_cnt_inc;
            done_r      <= run_hit;
          end else begin
            // idle motor: clear the average, keep learning the zero level
            held_avg_r    <= '0;
            held_scaled_r <= '0;
            run_sum_r     <= '0;
            run_count_r   <= '0;
            cal_sum_r     <= cal_sum_add;
            cal_count_r   <= cal_cnt_inc;
            done_r        <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (active) begin
              held_avg_r  <= div_rsp.quotient[SAMPLE_BITS-1:0];
              run_sum_r   <= '0;
              run_count_r <= '0;
            end else begin
              zero_offset_r <= div_rsp.quotient[SAMPLE_BITS-1:0];
              cal_sum_r     <= '0;
              cal_count_r   <= '0;
            end
          end
        end
        S_SAT: begin
          held_scaled_r <= scaled;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.average_done    <= done_r;
      out_data_r.average_current <= held_avg_r;
      out_data_r.scaled_current  <= held_scaled_r;
      out_data_r.zero_level      <= zero_offset_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  `include "motor_current_block_averager_assert.svh"

  // divider only launched from the update step
  `MCBA_ASSERT_NOW(a_div_start_update, div_req.start, state_r == S_UPDATE, "divider start outside update")
  // divider finishes only while the sequencer waits on it
  `MCBA_ASSERT_NOW(a_div_done_wait, div_rsp.done, state_r == S_DIV, "divider done outside wait state")
  // a finished block always clears the count below the maximum
  `MCBA_ASSERT_NOW(a_run_count_bound, state_r == S_IDLE, run_count_r < AVG_CNT_W'(MAX_AVG_LEN), "block count past maximum between words")
  // an accepted word always goes to the update step
  `MCBA_ASSERT_NEXT(a_accept_update, in_valid && !in_stall, state_r == S_UPDATE, "accepted word not processed")

endmodule
